[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL that checks its own behaviour.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a on a clock edge implies condition c on the same edge.
`define ASSERT_SAME(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error(msg);

// Condition a on a clock edge implies condition c on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error(msg);

`endif

[rtl/core/hbpwm_pkg.sv]
// Package with constants and codes for the H-bridge PWM core.
`timescale 1ns / 1ps

package hbpwm_pkg;

	localparam int NUM_MOTORS_DEF = 2;

	localparam int THR_W   = 16;
	localparam int BRAKE_W = 20;
	localparam int TIME_W  = 32;
	localparam int DIR_W   = 2;
	localparam int DUTY_W  = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [DUTY_W-1:0] DUTY_MAX  = 12'd2048;
	localparam logic [DUTY_W-1:0] DUTY_IDLE = 12'd660;
	localparam int DUTY_SPAN = 1388;
	localparam int SPAN_W    = 11;
	localparam int PROD_W    = THR_W + SPAN_W;

	localparam logic [DIR_W-1:0] DIR_STOP    = 2'd0;
	localparam logic [DIR_W-1:0] DIR_FORWARD = 2'd1;

	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BRAKE_US   = 2'd2;

	localparam logic [THR_W-1:0]   FULL_SCALE_RST = 16'd1000;
	localparam logic [THR_W-1:0]   DEADBAND_RST   = 16'd0;
	localparam logic [BRAKE_W-1:0] BRAKE_US_RST   = 20'd100000;

endpackage

[rtl/core/h_bridge_pwm_with_reverse_brake_core.sv]
// Top level of the H-bridge PWM core with a brake before each reversal.
// An item that drives the motor goes from acceptance through a decision state, then 27
// restoring-divider steps of one quotient bit each, then an output state that registers its result.
// Items that stop, brake, fall in the dead zone, have a zero divisor or no motor skip the divider.
// A new item is taken only in the idle state, once the last is in the output register; a full output register stalls.
// Reset clears the configuration registers to their defaults and every motor to stop with no brake pending.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module h_bridge_pwm_with_reverse_brake_core
	import hbpwm_pkg::*;
#(
	parameter int NUM_MOTORS = NUM_MOTORS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  motor_sel,
	input  logic [DIR_W-1:0]      direction,
	input  logic [THR_W-1:0]      throttle,
	input  logic [TIME_W-1:0]     time_us,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  motor_out,
	output logic [DUTY_W-1:0]     pwm_duty,
	output logic                  pin_a,
	output logic                  pin_b,
	output logic                  is_braking
);

	localparam int IDX_W     = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
	localparam int DIV_STEPS = PROD_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [THR_W-1:0]   full_scale_q;
	logic [THR_W-1:0]   deadband_q;
	logic [BRAKE_W-1:0] brake_us_q;

	// Per-motor state.
	logic [DIR_W-1:0]  prev_dir_q   [NUM_MOTORS];
	logic              pending_q    [NUM_MOTORS];
	logic [TIME_W-1:0] brake_start_q[NUM_MOTORS];

	// Latched request.
	logic              sel_q;
	logic [DIR_W-1:0]  dir_q;
	logic [THR_W-1:0]  thr_q;
	logic [TIME_W-1:0] time_q;

	// Decision results carried to the output stage.
	logic braking_q;
	logic pa_q;
	logic pb_q;
	logic duty_zero_q;
	logic duty_full_q;

	// Shared divider datapath: remainder and combined dividend/quotient shift register.
	logic [THR_W-1:0]  rem_q;
	logic [PROD_W-1:0] dq_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              out_valid_q;
	logic              motor_out_q;
	logic [DUTY_W-1:0] pwm_duty_q;
	logic              pin_a_q;
	logic              pin_b_q;
	logic              is_braking_q;

	// Decision logic, evaluated in the multiply cycle.
	logic [IDX_W-1:0]  idx;
	logic              in_range;
	logic [DIR_W-1:0]  prev_dir;
	logic              reversing;
	logic [TIME_W-1:0] elapsed;
	logic              brake_done;
	logic              braking;
	logic              drive;

	// Divider step.
	logic [THR_W:0]   shifted;
	logic [THR_W+1:0] diff;
	logic             q_bit;

	logic [DUTY_W-1:0] duty_final;
	logic              out_free;

	assign idx       = IDX_W'(sel_q);
	assign in_range  = 32'(sel_q) < NUM_MOTORS;
	assign prev_dir  = prev_dir_q[idx];
	assign reversing = in_range && (prev_dir != DIR_STOP) && (dir_q != prev_dir);
	assign elapsed   = time_q - brake_start_q[idx];
	assign brake_done = elapsed >= TIME_W'(brake_us_q);
	assign braking   = reversing && !(pending_q[idx] && brake_done);
	assign drive     = in_range && !braking && (dir_q != DIR_STOP);

	assign shifted = {rem_q, dq_q[PROD_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, full_scale_q};
	assign q_bit   = !diff[THR_W+1];

	always_comb begin
		if (duty_zero_q) begin
			duty_final = '0;
		end else if (duty_full_q || (dq_q > PROD_W'(DUTY_SPAN))) begin
			duty_final = DUTY_MAX;
		end else begin
			duty_final = DUTY_W'(dq_q[SPAN_W-1:0]) + DUTY_IDLE;
		end
	end

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_scale_q <= FULL_SCALE_RST;
			deadband_q   <= DEADBAND_RST;
			brake_us_q   <= BRAKE_US_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FULL_SCALE: full_scale_q <= cfg_data[THR_W-1:0];
				REG_DEADBAND:   deadband_q   <= cfg_data[THR_W-1:0];
				REG_BRAKE_US:   brake_us_q   <= cfg_data[BRAKE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < NUM_MOTORS; m++) begin
				prev_dir_q[m]    <= DIR_STOP;
				pending_q[m]     <= 1'b0;
				brake_start_q[m] <= '0;
			end
		end else if (state_q == S_MUL && in_range) begin
			if (reversing) begin
				if (pending_q[idx]) begin
					if (brake_done) begin
						pending_q[idx] <= 1'b0;
					end
				end else begin
					pending_q[idx]     <= 1'b1;
					brake_start_q[idx] <= time_q;
				end
			end
			if (!braking) begin
				prev_dir_q[idx] <= dir_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			sel_q  <= motor_sel;
			dir_q  <= direction;
			thr_q  <= throttle;
			time_q <= time_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			braking_q    <= 1'b0;
			pa_q         <= 1'b0;
			pb_q         <= 1'b0;
			duty_zero_q  <= 1'b0;
			duty_full_q  <= 1'b0;
			rem_q        <= '0;
			dq_q         <= '0;
			cnt_q        <= '0;
			motor_out_q  <= 1'b0;
			pwm_duty_q   <= '0;
			pin_a_q      <= 1'b0;
			pin_b_q      <= 1'b0;
			is_braking_q <= 1'b0;
		end else begin
			// In the output cycle the new result takes the register instead.
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					braking_q   <= braking && in_range;
					pa_q        <= drive && (dir_q == DIR_FORWARD);
					pb_q        <= drive && (dir_q != DIR_FORWARD);
					duty_zero_q <= !drive || (thr_q <= deadband_q);
					duty_full_q <= (full_scale_q == '0);
					rem_q       <= '0;
					dq_q        <= PROD_W'(thr_q) * PROD_W'(DUTY_SPAN);
					cnt_q       <= CNT_W'(DIV_STEPS - 1);
					// The divider only runs when its quotient reaches the output.
					if (!drive || (thr_q <= deadband_q) || (full_scale_q == '0)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= q_bit ? diff[THR_W-1:0] : shifted[THR_W-1:0];
					dq_q  <= {dq_q[PROD_W-2:0], q_bit};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						motor_out_q  <= sel_q;
						pwm_duty_q   <= duty_final;
						pin_a_q      <= pa_q;
						pin_b_q      <= pb_q;
						is_braking_q <= braking_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign motor_out  = motor_out_q;
	assign pwm_duty   = pwm_duty_q;
	assign pin_a      = pin_a_q;
	assign pin_b      = pin_b_q;
	assign is_braking = is_braking_q;

	`ASSERT_NEXT(a_busy_after_request, clk, arst_n, in_valid && in_ready, !in_ready, "request taken while busy")
	`ASSERT_SAME(a_pins_exclusive, clk, arst_n, out_valid, !(pin_a && pin_b), "both bridge inputs high")
	`ASSERT_SAME(a_brake_idle, clk, arst_n, out_valid && is_braking, !pin_a && !pin_b && (pwm_duty == '0), "drive during brake")
	`ASSERT_SAME(a_duty_range, clk, arst_n, out_valid && (pwm_duty != '0), (pwm_duty >= DUTY_IDLE) && (pwm_duty <= DUTY_MAX) && (pin_a || pin_b), "duty out of range")

endmodule

[bench/h_bridge_pwm_with_reverse_brake_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the H-bridge PWM core: directed table, then randomised phases.

module h_bridge_pwm_with_reverse_brake_core_tb;
	import hbpwm_pkg::*;

	localparam logic [DIR_W-1:0]     DIR_BACKWARD = 2'd2;
	localparam logic [DIR_W-1:0]     DIR_SPARE    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 2'd3;

	localparam int SETTLE_CYCLES   = 40;
	localparam int STALL_LIMIT     = 3000;
	localparam int PHASES          = 8;
	localparam int FIXED_PHASES    = 5;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int PRESSURE_AFTER  = 400;
	localparam int PRESSURE_CYCLES = 300;
	localparam int N_ROWS          = 21;

	typedef struct packed {
		logic              motor;
		logic [DUTY_W-1:0] duty;
		logic              pa;
		logic              pb;
		logic              brk;
	} drive_t;

	typedef struct packed {
		logic              sel;
		logic [DIR_W-1:0]  dir;
		logic [THR_W-1:0]  thr;
		logic [TIME_W-1:0] t;
		logic              typed;
		drive_t            want;
	} step_t;

	// Directed requests; typed rows carry their own expectation, the rest use the predictor.
	localparam step_t ROWS [N_ROWS] = '{
		'{1'b0, DIR_FORWARD,  16'd1000,  32'd0,         1'b1, '{1'b0, 12'd2048, 1'b1, 1'b0, 1'b0}},
		'{1'b0, DIR_FORWARD,  16'd0,     32'd10,        1'b1, '{1'b0, 12'd0,    1'b1, 1'b0, 1'b0}},
		'{1'b0, DIR_FORWARD,  16'hFFFF,  32'd20,        1'b1, '{1'b0, 12'd2048, 1'b1, 1'b0, 1'b0}},
		'{1'b0, DIR_BACKWARD, 16'd500,   32'd100,       1'b1, '{1'b0, 12'd0,    1'b0, 1'b0, 1'b1}},
		'{1'b0, DIR_BACKWARD, 16'd500,   32'd50000,     1'b0, '0},
		'{1'b0, DIR_BACKWARD, 16'd500,   32'd100100,    1'b0, '0},
		'{1'b0, DIR_STOP,     16'd500,   32'd100200,    1'b0, '0},
		'{1'b0, DIR_STOP,     16'd0,     32'd200200,    1'b0, '0},
		'{1'b1, DIR_SPARE,    16'd1,     32'hFFFFFF00,  1'b0, '0},
		'{1'b1, DIR_FORWARD,  16'd777,   32'hFFFFFFF0,  1'b0, '0},
		'{1'b1, DIR_FORWARD,  16'd777,   32'h00000010,  1'b0, '0},
		'{1'b1, DIR_FORWARD,  16'd777,   32'h000186A0,  1'b0, '0},
		'{1'b0, DIR_FORWARD,  16'd300,   32'd300000,    1'b0, '0},
		'{1'b0, DIR_BACKWARD, 16'd300,   32'd300010,    1'b0, '0},
		'{1'b0, DIR_FORWARD,  16'd300,   32'd300020,    1'b0, '0},
		'{1'b0, DIR_BACKWARD, 16'd300,   32'd500000,    1'b0, '0},
		'{1'b1, DIR_STOP,     16'hFFFF,  32'h000186B0,  1'b0, '0},
		'{1'b1, DIR_STOP,     16'hFFFF,  32'h00030D40,  1'b0, '0},
		'{1'b1, DIR_STOP,     16'hFFFF,  32'h00030D50,  1'b0, '0},
		'{1'b1, DIR_BACKWARD, 16'd1,     32'hFFFFFFFF,  1'b0, '0},
		'{1'b0, DIR_STOP,     16'd0,     32'hFFFFFFFF,  1'b0, '0}
	};

	localparam int unsigned PH_FULL_SCALE [FIXED_PHASES] = '{1000, 1, 65535, 0, 500};
	localparam int unsigned PH_DEADBAND   [FIXED_PHASES] = '{0, 0, 65535, 100, 50};
	localparam int unsigned PH_BRAKE_US   [FIXED_PHASES] = '{100000, 0, 20'hFFFFF, 5000, 1000000};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  motor_sel;
	logic [DIR_W-1:0]      direction;
	logic [THR_W-1:0]      throttle;
	logic [TIME_W-1:0]     time_us;
	logic                  out_valid;
	logic                  out_ready;
	logic                  motor_out;
	logic [DUTY_W-1:0]     pwm_duty;
	logic                  pin_a;
	logic                  pin_b;
	logic                  is_braking;

	// Shadow of the block's registers and per-motor state.
	logic [THR_W-1:0]   full_scale = FULL_SCALE_RST;
	logic [THR_W-1:0]   deadband   = DEADBAND_RST;
	logic [BRAKE_W-1:0] brake_us   = BRAKE_US_RST;
	logic [DIR_W-1:0]   held_dir    [2] = '{DIR_STOP, DIR_STOP};
	logic               brake_armed [2] = '{1'b0, 1'b0};
	logic [TIME_W-1:0]  brake_stamp [2] = '{32'd0, 32'd0};

	drive_t drive_expected [$];
	int     n_fail       = 0;
	int     results_seen = 0;
	int     quiet_cycles = 0;
	bit     burst        = 1'b0;

	h_bridge_pwm_with_reverse_brake_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.motor_sel  (motor_sel),
		.direction  (direction),
		.throttle   (throttle),
		.time_us    (time_us),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.motor_out  (motor_out),
		.pwm_duty   (pwm_duty),
		.pin_a      (pin_a),
		.pin_b      (pin_b),
		.is_braking (is_braking)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Works out the drive levels for one request and advances the motor state.
	function automatic drive_t predict_drive(logic sel, logic [DIR_W-1:0] dir,
			logic [THR_W-1:0] thr, logic [TIME_W-1:0] now);
		logic [63:0]       scaled;
		logic [DUTY_W-1:0] duty;
		logic [TIME_W-1:0] elapsed;
		logic              hold;
		drive_t            r;
		r = '0;
		r.motor = sel;
		hold = 1'b0;
		if (thr <= deadband) begin
			duty = '0;
		end else if (full_scale == '0) begin
			duty = DUTY_MAX;
		end else begin
			scaled = 64'(thr) * 64'(DUTY_SPAN) / 64'(full_scale) + 64'(DUTY_IDLE);
			duty = (scaled > 64'(DUTY_MAX)) ? DUTY_MAX : scaled[DUTY_W-1:0];
		end
		if (held_dir[sel] != DIR_STOP && dir != held_dir[sel]) begin
			if (brake_armed[sel]) begin
				elapsed = now - brake_stamp[sel];
				if (elapsed >= 32'(brake_us))
					brake_armed[sel] = 1'b0;
				else
					hold = 1'b1;
			end else begin
				brake_armed[sel] = 1'b1;
				brake_stamp[sel] = now;
				hold = 1'b1;
			end
		end
		if (!hold)
			held_dir[sel] = dir;
		if (!hold && dir != DIR_STOP) begin
			r.duty = duty;
			if (dir == DIR_FORWARD)
				r.pa = 1'b1;
			else
				r.pb = 1'b1;
		end
		r.brk = hold;
		return r;
	endfunction

	// Mostly back to back or short gaps, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FULL_SCALE: full_scale = data[THR_W-1:0];
			REG_DEADBAND:   deadband   = data[THR_W-1:0];
			REG_BRAKE_US:   brake_us   = data;
			default: ;
		endcase
	endtask

	task automatic offer_drive(input step_t s);
		int unsigned g;
		drive_t      want;
		g = burst ? 0 : pick_gap();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid  <= 1'b1;
		motor_sel <= s.sel;
		direction <= s.dir;
		throttle  <= s.thr;
		time_us   <= s.t;
		do @(posedge clk); while (!in_ready);
		want = predict_drive(s.sel, s.dir, s.thr, s.t);
		drive_expected.push_back(s.typed ? s.want : want);
	endtask

	// Waits until every expected result has arrived, then lets the block settle.
	task automatic drain();
		while (drive_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		step_t              s;
		int unsigned        r;
		int                 v;
		logic [THR_W-1:0]   fs;
		logic [THR_W-1:0]   dz;
		logic [BRAKE_W-1:0] brk;
		logic [TIME_W-1:0]  t_now;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		motor_sel = 1'b0;
		direction = DIR_STOP;
		throttle  = '0;
		time_us   = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_ROWS; i++)
			offer_drive(ROWS[i]);
		in_valid <= 1'b0;

		t_now = $urandom;
		for (int p = 0; p < PHASES; p++) begin
			drain();
			if (p < FIXED_PHASES) begin
				fs  = THR_W'(PH_FULL_SCALE[p]);
				dz  = THR_W'(PH_DEADBAND[p]);
				brk = BRAKE_W'(PH_BRAKE_US[p]);
			end else begin
				fs  = THR_W'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 2000) :
						$urandom_range(1, 65535));
				dz  = THR_W'($urandom_range(0, 2000));
				brk = BRAKE_W'($urandom_range(0, 200000));
			end
			// The bits above a 16-bit register are don't-care and get random values.
			write_reg(REG_FULL_SCALE, {4'($urandom_range(0, 15)), fs});
			write_reg(REG_DEADBAND, {4'($urandom_range(0, 15)), dz});
			write_reg(REG_BRAKE_US, brk);
			if (p == 3)
				write_reg(REG_SPARE, 20'($urandom));
			cfg_valid <= 1'b0;
			burst = (p % 3 == 1);

			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				s = '0;
				s.sel = 1'($urandom_range(0, 1));
				r = $urandom_range(0, 9);
				if (r < 2)
					s.dir = DIR_STOP;
				else if (r < 6)
					s.dir = DIR_FORWARD;
				else if (r < 9)
					s.dir = DIR_BACKWARD;
				else
					s.dir = DIR_SPARE;
				case ($urandom_range(0, 7))
					0: s.thr = '0;
					1: s.thr = '1;
					2: begin
						v = int'(deadband) + int'($urandom_range(0, 1));
						if (v > 65535)
							v = 65535;
						s.thr = v[THR_W-1:0];
					end
					3: begin
						v = int'(full_scale) + int'($urandom_range(0, 2)) - 1;
						if (v < 0)
							v = 0;
						if (v > 65535)
							v = 65535;
						s.thr = v[THR_W-1:0];
					end
					default: s.thr = THR_W'($urandom_range(0, 65535));
				endcase
				// Time mostly moves forward; some requests land exactly on the end of a brake.
				case ($urandom_range(0, 9))
					0: t_now = $urandom;
					1: t_now = brake_stamp[s.sel] + 32'(brake_us);
					2: t_now = brake_stamp[s.sel] + 32'(brake_us) - 32'd1;
					default: t_now = t_now + $urandom_range(0, brake_us / 3 + 16);
				endcase
				s.t = t_now;
				offer_drive(s);
			end
			in_valid <= 1'b0;
		end

		drain();
		if (drive_expected.size() != 0) begin
			$error("%0d expected drive results never arrived", drive_expected.size());
			n_fail++;
		end
		if (n_fail == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Result side: random back-pressure, plus one long hold-off so the block fills and stalls.
	initial begin
		int unsigned g;
		bit          held_long;
		held_long = 1'b0;
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held_long && results_seen >= PRESSURE_AFTER) begin
				held_long = 1'b1;
				out_ready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(posedge clk);
			end else begin
				g = pick_gap();
				if (g != 0) begin
					out_ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(20, 80)) @(posedge clk);
			else
				repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		drive_t got;
		drive_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			got = '{motor_out, pwm_duty, pin_a, pin_b, is_braking};
			if (drive_expected.size() == 0) begin
				$error("drive result for motor %0d with no request outstanding", got.motor);
				n_fail++;
			end else begin
				want = drive_expected.pop_front();
				if (got.motor !== want.motor) begin
					$error("motor_out: expected %0d, got %0d", want.motor, got.motor);
					n_fail++;
				end
				if (got.duty !== want.duty) begin
					$error("pwm_duty: expected %0d, got %0d", want.duty, got.duty);
					n_fail++;
				end
				if (got.pa !== want.pa) begin
					$error("pin_a: expected %0d, got %0d", want.pa, got.pa);
					n_fail++;
				end
				if (got.pb !== want.pb) begin
					$error("pin_b: expected %0d, got %0d", want.pb, got.pb);
					n_fail++;
				end
				if (got.brk !== want.brk) begin
					$error("is_braking: expected %0d, got %0d", want.brk, got.brk);
					n_fail++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/hbpwm_pkg.sv
rtl/core/h_bridge_pwm_with_reverse_brake_core.sv
bench/h_bridge_pwm_with_reverse_brake_core_tb.sv
